[hdl/sft_pkg.sv]
// shared types and constants for the sensor filter threshold counter
`default_nettype none

package sft_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;

  // sum of three samples and its magnitude
  localparam int SUM_W    = SAMPLE_WIDTH + 2;
  localparam int MAG_W    = SAMPLE_WIDTH + 1;
  // divide by three through a reciprocal multiply
  localparam int DIV_SHIFT = MAG_W + 2;
  localparam int RECIP_W   = DIV_SHIFT - 1;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV3_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd3);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MODE_W     = 2;

  localparam logic CFG_IDX_MODE = 1'b0;

  localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic [MAG_W-1:0]               mag_t;
  typedef logic [SAMPLE_WIDTH-1:0]        quo_t;
  typedef logic [PROD_W-1:0]              prod_t;
  typedef logic [COUNT_WIDTH-1:0]         count_t;

  typedef struct packed {
    sample_t wlo;
    sample_t whi;
    sample_t alo;
    sample_t ahi;
  } limits_t;

  typedef struct packed {
    logic load;
    logic restart;
  } hit_ctl_t;

endpackage

`default_nettype wire

[hdl/sft_tap_cell.sv]
// one history tap: holds a sample and hands it to the next tap on each shift
`default_nettype none

module sft_tap_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire logic            clear,
  input  wire sft_pkg::sample_t d,
  output sft_pkg::sample_t     q
);
  import sft_pkg::*;

  sample_t data_r;
  sample_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (shift_en) begin
      data_nxt = clear ? '0 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;

endmodule

`default_nettype wire

[hdl/sft_hit_cell.sv]
// one limit check: compare against a limit and keep a saturating hit count
`default_nettype none

module sft_hit_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sft_pkg::hit_ctl_t ctl,
  input  wire logic              high_sel,
  input  wire sft_pkg::sample_t  value,
  input  wire sft_pkg::sample_t  limit,
  output logic                   flag,
  output sft_pkg::count_t        count
);
  import sft_pkg::*;

  logic   flag_r;
  logic   flag_nxt;
  count_t count_r;
  count_t count_nxt;
  count_t base;

  always_comb begin
    flag_nxt  = high_sel ? (value >= limit) : (value <= limit);
    base      = ctl.restart ? '0 : count_r;
    count_nxt = base;
    if (flag_nxt && (base != '1)) begin
      count_nxt = base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      flag_r <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.load) begin
      count_r <= count_nxt;
    end
  end

  assign flag  = flag_r;
  assign count = count_r;

endmodule

`default_nettype wire

[hdl/sensor_filter_threshold_counter_core.sv]
// top level: sample filter with limit flags and saturating hit counters
//
// Usage: one transaction on the input channel carries a signed sample, four
// limits and a last mark; each gives exactly one transaction on the output
// channel with the filtered value, four limit flags, four run counts and
// run_end. cfg register 0 selects pass, three-sample mean or median.
// Stages: stage 1 filter/sum, stage 2 reciprocal multiply for the mean,
// stage 3 quotient correction, output register limit compare and count.
// Throughput: one transaction per cycle with out_stall low; each stage has
// its own valid and moves on whenever the stage after it is empty or moving.
// History lives in a chain of two tap cells shifted at input accept; the
// four counters live in hit cells updated when a result enters the output
// register, and restart from zero for the first result after a last one.
// Reset: history, counters, mode and all valids go to zero, no output.
// Stall: out_stall holds the output register; the pipeline keeps filling
// behind it and raises in_stall only once the first stage cannot move.
`default_nettype none

module sensor_filter_threshold_counter_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [sft_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [sft_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [sft_pkg::CFG_DATA_W-1:0]           cfg_prdata,
  output logic                                     cfg_pready,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire sft_pkg::sample_t                    in_sample,
  input  wire sft_pkg::sample_t                    in_warn_low,
  input  wire sft_pkg::sample_t                    in_warn_high,
  input  wire sft_pkg::sample_t                    in_alarm_low,
  input  wire sft_pkg::sample_t                    in_alarm_high,
  input  wire logic                                in_last,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output sft_pkg::sample_t                         out_filtered_value,
  output logic                                     out_flag_warn_low,
  output logic                                     out_flag_warn_high,
  output logic                                     out_flag_alarm_low,
  output logic                                     out_flag_alarm_high,
  output sft_pkg::count_t                          out_count_warn_low,
  output sft_pkg::count_t                          out_count_warn_high,
  output sft_pkg::count_t                          out_count_alarm_low,
  output sft_pkg::count_t                          out_count_alarm_high,
  output logic                                     out_run_end
);
  import sft_pkg::*;

  logic [MODE_W-1:0] mode_r;

  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdyo;
  logic adv1, adv2, adv3, advo;

  sample_t prev_one, prev_two;

  // stage 1
  sum_t    sum;
  sum_t    sum_abs;
  sample_t median;
  sample_t s1_byp_nxt;
  logic    s1_div_r;
  logic    s1_neg_r;
  mag_t    s1_mag_r;
  sample_t s1_byp_r;
  limits_t s1_lim_r;
  logic    s1_last_r;
  limits_t in_lim;

  // stage 2
  prod_t   prod;
  logic    s2_div_r;
  logic    s2_neg_r;
  mag_t    s2_mag_r;
  quo_t    s2_quo_r;
  sample_t s2_byp_r;
  limits_t s2_lim_r;
  logic    s2_last_r;

  // stage 3
  mag_t    times3;
  mag_t    rem;
  quo_t    quo;
  sample_t s3_val_nxt;
  sample_t s3_val_r;
  limits_t s3_lim_r;
  logic    s3_last_r;

  // output stage
  sample_t  out_val_r;
  logic     out_last_r;
  hit_ctl_t hit_ctl;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_MODE)
                      ? CFG_DATA_W'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_MODE)) begin
      mode_r <= cfg_pwdata[MODE_W-1:0];
    end
  end

  // stage flow control
  assign rdyo = !vo_r || !out_stall;
  assign rdy3 = !v3_r || rdyo;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign adv1 = in_valid && rdy1;
  assign adv2 = v1_r && rdy2;
  assign adv3 = v2_r && rdy3;
  assign advo = v3_r && rdyo;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdyo) begin
        vo_r <= v3_r;
      end
    end
  end

  // history chain
  sft_tap_cell u_tap_one (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (adv1),
    .clear    (in_last),
    .d        (in_sample),
    .q        (prev_one)
  );

  sft_tap_cell u_tap_two (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (adv1),
    .clear    (in_last),
    .d        (prev_one),
    .q        (prev_two)
  );

  // stage 1: window sum and median
  assign in_lim = '{wlo: in_warn_low, whi: in_warn_high,
                    alo: in_alarm_low, ahi: in_alarm_high};

  always_comb begin
    sum     = SUM_W'(in_sample) + SUM_W'(prev_one) + SUM_W'(prev_two);
    sum_abs = sum[SUM_W-1] ? -sum : sum;
    if (in_sample >= prev_one) begin
      if (prev_one >= prev_two) begin
        median = prev_one;
      end else begin
        median = (in_sample >= prev_two) ? prev_two : in_sample;
      end
    end else begin
      if (in_sample >= prev_two) begin
        median = in_sample;
      end else begin
        median = (prev_one >= prev_two) ? prev_two : prev_one;
      end
    end
    unique case (mode_r)
      MODE_MEDIAN: s1_byp_nxt = median;
      default:     s1_byp_nxt = in_sample;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_div_r  <= (mode_r == MODE_MEAN);
      s1_neg_r  <= sum[SUM_W-1];
      s1_mag_r  <= sum_abs[MAG_W-1:0];
      s1_byp_r  <= s1_byp_nxt;
      s1_lim_r  <= in_lim;
      s1_last_r <= in_last;
    end
  end

  // stage 2: reciprocal multiply
  assign prod = PROD_W'(s1_mag_r) * PROD_W'(DIV3_RECIP);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_div_r  <= s1_div_r;
      s2_neg_r  <= s1_neg_r;
      s2_mag_r  <= s1_mag_r;
      s2_quo_r  <= prod[DIV_SHIFT +: SAMPLE_WIDTH];
      s2_byp_r  <= s1_byp_r;
      s2_lim_r  <= s1_lim_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: quotient correction and sign
  always_comb begin
    times3 = (MAG_W'(s2_quo_r) << 1) + MAG_W'(s2_quo_r);
    rem    = s2_mag_r - times3;
    quo    = (rem >= MAG_W'(3)) ? s2_quo_r + 1'b1 : s2_quo_r;
    if (s2_div_r) begin
      s3_val_nxt = s2_neg_r ? -sample_t'(quo) : sample_t'(quo);
    end else begin
      s3_val_nxt = s2_byp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_val_r  <= s3_val_nxt;
      s3_lim_r  <= s2_lim_r;
      s3_last_r <= s2_last_r;
    end
  end

  // output stage: limit checks and counters
  assign hit_ctl.load    = advo;
  assign hit_ctl.restart = out_last_r;

  always_ff @(posedge clk) begin
    if (advo) begin
      out_val_r <= s3_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_last_r <= 1'b0;
    end else if (advo) begin
      out_last_r <= s3_last_r;
    end
  end

  sft_hit_cell u_hit_warn_low (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hit_ctl),
    .high_sel (1'b0),
    .value    (s3_val_r),
    .limit    (s3_lim_r.wlo),
    .flag     (out_flag_warn_low),
    .count    (out_count_warn_low)
  );

  sft_hit_cell u_hit_warn_high (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hit_ctl),
    .high_sel (1'b1),
    .value    (s3_val_r),
    .limit    (s3_lim_r.whi),
    .flag     (out_flag_warn_high),
    .count    (out_count_warn_high)
  );

  sft_hit_cell u_hit_alarm_low (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hit_ctl),
    .high_sel (1'b0),
    .value    (s3_val_r),
    .limit    (s3_lim_r.alo),
    .flag     (out_flag_alarm_low),
    .count    (out_count_alarm_low)
  );

  sft_hit_cell u_hit_alarm_high (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hit_ctl),
    .high_sel (1'b1),
    .value    (s3_val_r),
    .limit    (s3_lim_r.ahi),
    .flag     (out_flag_alarm_high),
    .count    (out_count_alarm_high)
  );

  assign out_valid          = vo_r;
  assign out_filtered_value = out_val_r;
  assign out_run_end        = out_last_r;

endmodule

`default_nettype wire

[hdl/sft_checker.sv]
// port-level checker for the sensor filter threshold counter, with its bind
`default_nettype none

module sft_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire sft_pkg::sample_t out_filtered_value,
  input wire logic             out_flag_warn_low,
  input wire logic             out_flag_warn_high,
  input wire logic             out_flag_alarm_low,
  input wire logic             out_flag_alarm_high,
  input wire sft_pkg::count_t  out_count_warn_low,
  input wire sft_pkg::count_t  out_count_warn_high,
  input wire sft_pkg::count_t  out_count_alarm_low,
  input wire sft_pkg::count_t  out_count_alarm_high
);
  import sft_pkg::*;

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_value))
    else $error("stalled output transaction changed");

  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  a_flag_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_flag_warn_low   || (out_count_warn_low   != '0)) &&
                  (!out_flag_warn_high  || (out_count_warn_high  != '0)) &&
                  (!out_flag_alarm_low  || (out_count_alarm_low  != '0)) &&
                  (!out_flag_alarm_high || (out_count_alarm_high != '0)))
    else $error("limit hit not reflected in its count");

endmodule

bind sensor_filter_threshold_counter_core sft_checker u_sft_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_filtered_value   (out_filtered_value),
  .out_flag_warn_low    (out_flag_warn_low),
  .out_flag_warn_high   (out_flag_warn_high),
  .out_flag_alarm_low   (out_flag_alarm_low),
  .out_flag_alarm_high  (out_flag_alarm_high),
  .out_count_warn_low   (out_count_warn_low),
  .out_count_warn_high  (out_count_warn_high),
  .out_count_alarm_low  (out_count_alarm_low),
  .out_count_alarm_high (out_count_alarm_high)
);

`default_nettype wire
